// ===== sv/idad_pkg.sv =====
// Package: types, constants and helpers for the ISO date add-days block
`default_nettype none
package idad_pkg;

  typedef struct packed {
    logic [63:0] text_head;
    logic [15:0] text_tail;
    logic [3:0]  text_length;
    logic [31:0] day_count;
  } idad_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] out_head;
    logic [15:0] out_tail;
  } idad_out_t;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusInvalid  = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  localparam logic [7:0] CharDash = 8'h2D;
  localparam logic [7:0] CharZero = 8'h30;

  // ordinal of 9999-12-31
  localparam logic [21:0] LastOrd = 22'd3652058;

  // leap year test from the year split as century and year within century
  function automatic logic is_leap(input logic [6:0] cen, input logic [6:0] yic);
    logic r;
    if (yic == 7'd0) r = (cen[1:0] == 2'b00);
    else r = (yic[1:0] == 2'b00);
    return r;
  endfunction

  // floor(x / 100) by reciprocal multiplication, exact for every 14-bit x
  function automatic logic [13:0] div100(input logic [13:0] x);
    logic [27:0] prod;
    prod = 28'(x) * 28'd5243;
    return 14'(prod >> 19);
  endfunction

  // floor(x / 10) by reciprocal multiplication, exact for every 7-bit x
  function automatic logic [3:0] div10(input logic [6:0] x);
    logic [14:0] prod;
    prod = 15'(x) * 15'd205;
    return 4'(prod >> 11);
  endfunction

  // days in the year before the first of month m (1..12)
  function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
    logic [8:0] r;
    case (m)
      4'd1: r = 9'd0;
      4'd2: r = 9'd31;
      4'd3: r = 9'd59;
      4'd4: r = 9'd90;
      4'd5: r = 9'd120;
      4'd6: r = 9'd151;
      4'd7: r = 9'd181;
      4'd8: r = 9'd212;
      4'd9: r = 9'd243;
      4'd10: r = 9'd273;
      4'd11: r = 9'd304;
      default: r = 9'd334;
    endcase
    if (leap && m > 4'd2) r = r + 9'd1;
    return r;
  endfunction

  // length of month m
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2: r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // days from 0001-01-01 to January 1 of year cen*100+yic+1, via prior years p
  function automatic logic [21:0] days_to_p(input logic [6:0] cen, input logic [6:0] yic);
    logic [13:0] p;
    logic [21:0] r;
    p = 14'(cen) * 14'd100 + 14'(yic);
    r = 22'(p) * 22'd365 + 22'(p >> 2) - 22'(cen) + 22'(cen >> 2);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/iso_date_add_days.sv =====
// Top level of the ISO date add-days block
//
// Usage: drive start high with a transaction on in_i (date text, length,
// day count). busy stays low, so a transaction is accepted every cycle
// that start is high. Each one yields exactly one result on res_o,
// marked by done_o for one cycle. Throughput is one transaction per
// cycle; the seven register stages are parse, ordinal, add, year
// estimate, year correction, month split and formatting. The receiver
// cannot stall, so no result is held.
// Reset clears all valid bits; transactions in flight are dropped.
// Status 1 marks a malformed source date, status 2 a result past
// 9999-12-31; the date text is zero unless the status is ok.
//
`default_nettype none
module iso_date_add_days
  import idad_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  idad_in_t  in_i,
  output logic      done_o,
  output idad_out_t res_o
);

  assign busy = 1'b0;

  idad_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .item_i  (in_i),
    .valid_o (done_o),
    .res_o   (res_o)
  );

endmodule
`default_nettype wire

// ===== sv/idad_core.sv =====
// Pipeline core: parse, ordinal, add, year split, month split, format
`default_nettype none
module idad_core
  import idad_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  idad_in_t  item_i,
  output logic      valid_o,
  output idad_out_t res_o
);

  // stage 1: check the text and take the digits apart
  logic [7:0]  ch [10];
  logic        form_ok;
  logic [3:0]  dg [10];
  always_comb begin
    for (int i = 0; i < 8; i++) ch[i] = item_i.text_head[63-8*i -: 8];
    ch[8] = item_i.text_tail[15:8];
    ch[9] = item_i.text_tail[7:0];
    form_ok = (item_i.text_length == 4'd10) && ch[4] == CharDash && ch[7] == CharDash;
    for (int i = 0; i < 10; i++) begin
      dg[i] = ch[i][3:0];
      if (i != 4 && i != 7 && !(ch[i] >= 8'h30 && ch[i] <= 8'h39)) form_ok = 1'b0;
    end
  end

  logic        v1_q, ok1_q;
  logic [6:0]  cen1_q, yic1_q;
  logic [6:0]  m1_q;
  logic [6:0]  d1_q;
  logic [31:0] cnt1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    ok1_q  <= form_ok;
    cen1_q <= 7'(dg[0]) * 7'd10 + 7'(dg[1]);
    yic1_q <= 7'(dg[2]) * 7'd10 + 7'(dg[3]);
    m1_q   <= 7'(dg[5]) * 7'd10 + 7'(dg[6]);
    d1_q   <= 7'(dg[8]) * 7'd10 + 7'(dg[9]);
    cnt1_q <= item_i.day_count;
  end

  // stage 2: range checks and ordinal of the source date
  logic        leap1, ok2_d;
  logic [6:0]  pc, py;
  logic [21:0] ord2_d;
  always_comb begin
    leap1 = is_leap(cen1_q, yic1_q);
    ok2_d = ok1_q && !(cen1_q == 7'd0 && yic1_q == 7'd0) && m1_q != 7'd0 &&
            m1_q <= 7'd12 && d1_q != 7'd0 && d1_q <= 7'(month_len(m1_q[3:0], leap1));
    // previous year as century and year within century
    if (yic1_q == 7'd0) begin
      pc = cen1_q - 7'd1; py = 7'd99;
    end else begin
      pc = cen1_q; py = yic1_q - 7'd1;
    end
    ord2_d = days_to_p(pc, py) + 22'(days_before(m1_q[3:0], leap1)) + 22'(d1_q) - 22'd1;
  end

  logic        v2_q, ok2_q;
  logic [21:0] ord2_q;
  logic [31:0] cnt2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    ok2_q <= ok2_d; ord2_q <= ord2_d; cnt2_q <= cnt1_q;
  end

  // stage 3: add the count and flag overflow
  logic [32:0] sum3;
  assign sum3 = 33'(ord2_q) + 33'(cnt2_q);
  logic        v3_q;
  logic [1:0]  st3_q;
  logic [21:0] tgt3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    st3_q  <= !ok2_q ? StatusInvalid :
              (sum3 > 33'(LastOrd)) ? StatusOverflow : StatusOk;
    tgt3_q <= sum3[21:0];
  end

  // stage 4: estimate the prior-year count p = target*400/146097
  logic [43:0] est4;
  assign est4 = (44'(tgt3_q) * 44'd2939805) >> 30;  // close underestimate
  logic        v4_q;
  logic [1:0]  st4_q;
  logic [21:0] tgt4_q;
  logic [13:0] p4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    st4_q <= st3_q; tgt4_q <= tgt3_q; p4_q <= 14'(est4);
  end

  // stage 5: correct the estimate by looking at p-1, p, p+1 and p+2 side by side
  function automatic logic [21:0] dt(input logic [13:0] p);
    logic [13:0] c;
    c = div100(p);
    return 22'(p) * 22'd365 + 22'(p >> 2) - 22'(c) + 22'(c >> 2);
  endfunction
  logic [13:0] pm5, pe5, pp5, pq5, p5;
  logic [21:0] dm5, de5, dp5, dq5, base5;
  always_comb begin
    pe5 = (p4_q > 14'd9998) ? 14'd9998 : p4_q;
    pm5 = (pe5 != 14'd0) ? pe5 - 14'd1 : pe5;
    pp5 = (pe5 < 14'd9998) ? pe5 + 14'd1 : pe5;
    pq5 = (pp5 < 14'd9998) ? pp5 + 14'd1 : pp5;
    dm5 = dt(pm5);
    de5 = dt(pe5);
    dp5 = dt(pp5);
    dq5 = dt(pq5);
    // keep the largest candidate whose year start is not past the target
    p5 = pm5; base5 = dm5;
    if (de5 <= tgt4_q) begin
      p5 = pe5; base5 = de5;
    end
    if (dp5 <= tgt4_q) begin
      p5 = pp5; base5 = dp5;
    end
    if (dq5 <= tgt4_q) begin
      p5 = pq5; base5 = dq5;
    end
  end
  logic        v5_q;
  logic [1:0]  st5_q;
  logic [13:0] y5_q;
  logic [8:0]  doy5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    st5_q <= st4_q; y5_q <= p5 + 14'd1; doy5_q <= 9'(tgt4_q - base5);
  end

  // stage 6: month and day from the day of year, year digits
  logic [6:0] c6, yi6;
  logic       leap6;
  logic [3:0] m6;
  logic [4:0] d6;
  always_comb begin
    c6 = 7'(div100(y5_q));
    yi6 = 7'(y5_q - 14'(c6) * 14'd100);
    leap6 = is_leap(c6, yi6);
    m6 = 4'd1;
    for (int k = 2; k <= 12; k++)
      if (doy5_q >= days_before(4'(k), leap6)) m6 = 4'(k);
    d6 = 5'(doy5_q - days_before(m6, leap6) + 9'd1);
  end
  logic       v6_q;
  logic [1:0] st6_q;
  logic [6:0] c6_q, yi6_q;
  logic [3:0] m6_q;
  logic [4:0] d6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    st6_q <= st5_q; c6_q <= c6; yi6_q <= yi6; m6_q <= m6; d6_q <= d6;
  end

  // stage 7: format as ASCII
  function automatic logic [15:0] two(input logic [6:0] v);
    logic [3:0] t;
    t = div10(v);
    return {CharZero | 8'(t), CharZero | 8'(v - 7'(t) * 7'd10)};
  endfunction
  logic      v7_q;
  idad_out_t r7_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    r7_q.status <= st6_q;
    if (st6_q == StatusOk) begin
      r7_q.out_head <= {two(c6_q), two(yi6_q), CharDash, two(7'(m6_q)), CharDash};
      r7_q.out_tail <= two(7'(d6_q));
    end else begin
      r7_q.out_head <= '0;
      r7_q.out_tail <= '0;
    end
  end

  assign valid_o = v7_q;
  assign res_o   = r7_q;

`ifndef SYNTHESIS
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##7 valid_o) else $error("result lost");
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> res_o.status <= StatusOverflow) else $error("bad status");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.status != StatusOk) |-> (res_o.out_head == '0 && res_o.out_tail == '0))
    else $error("payload not cleared");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/iso_date_add_days_tb.sv =====
// Self-checking testbench for the ISO date add-days block
`default_nettype none
module iso_date_add_days_tb;
  import idad_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned YearCap = 10000;
  localparam int unsigned WatchLimit = 2000;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  idad_in_t  in_i;
  logic      done_o;
  idad_out_t res_o;

  idad_out_t date_results_q[$];
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_ok;
  int unsigned n_invalid;
  int unsigned n_overflow;
  int unsigned idle_cycles;

  iso_date_add_days dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .in_i  (in_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Calendar arithmetic for the predictor
  function automatic bit gregorian_leap(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    int unsigned lens[12];
    lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > 12) return 0;
    if (m == 2 && gregorian_leap(y)) return 29;
    return lens[m-1];
  endfunction

  function automatic int unsigned year_start(int unsigned y);
    int unsigned p;
    p = (y >= 1) ? y - 1 : 0;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic logic [7:0] text_char(idad_in_t it, int i);
    if (i < 8) return it.text_head[63 - 8*i -: 8];
    return it.text_tail[15 - 8*(i-8) -: 8];
  endfunction

  // Work out the shifted date, or the status that stops it
  function automatic idad_out_t shifted_date(idad_in_t it);
    idad_out_t r;
    int unsigned dig[10];
    int unsigned y, m, d, ord, target, doy;
    logic [7:0] ch;
    logic [7:0] txt[10];
    r = '0;
    r.status = StatusInvalid;
    if (it.text_length != 4'd10) return r;
    for (int i = 0; i < 10; i++) begin
      ch = text_char(it, i);
      if (i == 4 || i == 7) begin
        if (ch != CharDash) return r;
      end else begin
        if (ch < CharZero || ch > CharZero + 8'd9) return r;
        dig[i] = ch - CharZero;
      end
    end
    y = dig[0]*1000 + dig[1]*100 + dig[2]*10 + dig[3];
    m = dig[5]*10 + dig[6];
    d = dig[8]*10 + dig[9];
    if (y == 0 || m == 0 || m > 12 || d == 0 || d > days_in_month(y, m)) return r;
    ord = year_start(y) + d - 1;
    for (int unsigned k = 1; k < m; k++) ord += days_in_month(y, k);
    if (longint'(it.day_count) > longint'(year_start(YearCap) - 1 - ord)) begin
      r.status = StatusOverflow;
      return r;
    end
    target = ord + it.day_count;
    y = 1;
    while (y < YearCap - 1 && year_start(y + 1) <= target) y += (year_start(y + 400) <= target
                                                              && y + 400 < YearCap) ? 400 : 1;
    doy = target - year_start(y);
    m = 1;
    while (m < 12 && doy >= days_in_month(y, m)) begin
      doy -= days_in_month(y, m);
      m++;
    end
    d = doy + 1;
    txt = '{8'(y/1000) + CharZero, 8'(y/100%10) + CharZero, 8'(y/10%10) + CharZero,
            8'(y%10) + CharZero, CharDash, 8'(m/10) + CharZero, 8'(m%10) + CharZero,
            CharDash, 8'(d/10) + CharZero, 8'(d%10) + CharZero};
    r.status = StatusOk;
    for (int i = 0; i < 8; i++) r.out_head[63 - 8*i -: 8] = txt[i];
    r.out_tail = {txt[8], txt[9]};
    return r;
  endfunction

  function automatic idad_in_t date_item(int unsigned y, int unsigned m, int unsigned d,
                                         logic [31:0] cnt);
    idad_in_t it;
    it.text_head = {8'(y/1000) + CharZero, 8'(y/100%10) + CharZero,
                    8'(y/10%10) + CharZero, 8'(y%10) + CharZero, CharDash,
                    8'(m/10) + CharZero, 8'(m%10) + CharZero, CharDash};
    it.text_tail = {8'(d/10) + CharZero, 8'(d%10) + CharZero};
    it.text_length = 4'd10;
    it.day_count = cnt;
    return it;
  endfunction

  // Send one transaction and queue its expected result
  task automatic send_date(idad_in_t it);
    start <= 1'b1;
    in_i  <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    date_results_q.push_back(shifted_date(it));
    n_sent++;
  endtask

  task automatic pause_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (date_results_q.size() != 0) @(posedge clk_i);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    idad_out_t want;
    if (rst_ni && done_o) begin
      idle_cycles <= 0;
      if (date_results_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, res_o);
        n_errors++;
      end else begin
        want = date_results_q.pop_front();
        n_checked++;
        case (res_o.status)
          StatusOk:       n_ok++;
          StatusInvalid:  n_invalid++;
          StatusOverflow: n_overflow++;
          default: ;
        endcase
        if (res_o.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                   res_o.status);
        if (res_o.out_head !== want.out_head)
          $display("%0t: out_head expected %h actual %h", $realtime, want.out_head,
                   res_o.out_head);
        if (res_o.out_tail !== want.out_tail)
          $display("%0t: out_tail expected %h actual %h", $realtime, want.out_tail,
                   res_o.out_tail);
        if (res_o !== want) n_errors++;
      end
    end else if (start && !busy) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stop a run that has stopped moving
  always @(posedge clk_i) begin
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_extremes();
    send_date(date_item(1, 1, 1, 32'd0));
    send_date(date_item(9999, 12, 31, 32'd0));
    send_date(date_item(9999, 12, 31, 32'd1));
    send_date(date_item(1, 1, 1, 32'd3652058));
    send_date(date_item(1, 1, 1, 32'd3652059));
    send_date(date_item(1, 1, 1, 32'hFFFF_FFFF));
    send_date(date_item(2000, 2, 29, 32'd365));
    send_date(date_item(1900, 2, 28, 32'd1));
    send_date(date_item(2024, 12, 31, 32'd1));
    send_date(date_item(1999, 12, 31, 32'd60));
  endtask

  task automatic test_malformed();
    idad_in_t it;
    send_date(date_item(0, 5, 5, 32'd1));
    send_date(date_item(2021, 0, 5, 32'd1));
    send_date(date_item(2021, 13, 5, 32'd1));
    send_date(date_item(2021, 4, 0, 32'd1));
    send_date(date_item(2021, 4, 31, 32'd1));
    send_date(date_item(1900, 2, 29, 32'd1));
    it = date_item(2021, 4, 5, 32'd1);
    it.text_length = 4'd9;
    send_date(it);
    it.text_length = 4'd15;
    send_date(it);
    it = date_item(2021, 4, 5, 32'd1);
    it.text_head[31:24] = 8'h2F;
    send_date(it);
    it = date_item(2021, 4, 5, 32'd1);
    it.text_tail[7:0] = 8'h3A;
    send_date(it);
    it = date_item(2021, 4, 5, 32'd1);
    it.text_head[7:0] = 8'h2E;
    send_date(it);
    it = '1;
    send_date(it);
    it = '0;
    send_date(it);
  endtask

  task automatic test_random(int unsigned count);
    idad_in_t it;
    int unsigned burst;
    int unsigned y, m;
    for (int unsigned k = 0; k < count;) begin
      burst = $urandom_range(1, 40);
      for (int unsigned b = 0; b < burst; b++, k++) begin
        y = ($urandom_range(0, 9) == 0) ? $urandom_range(9990, 9999) : $urandom_range(1, 9999);
        m = $urandom_range(1, 12);
        it = date_item(y, m, $urandom_range(1, days_in_month(y, m)), 32'h0);
        case ($urandom_range(0, 9))
          0: it.day_count = $urandom();
          1: it.day_count = $urandom_range(0, 3652058);
          2: it.text_length = 4'($urandom_range(0, 15));
          3: begin
            it.text_head = {$urandom(), $urandom()};
            it.text_tail = 16'($urandom());
            it.day_count = $urandom();
          end
          4: it.text_tail = {8'($urandom_range(8'h30, 8'h33)), 8'($urandom_range(8'h30, 8'h39))};
          default: it.day_count = $urandom_range(0, 2000);
        endcase
        send_date(it);
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_ok = 0;
    n_invalid = 0;
    n_overflow = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    pause_sender(3);
    test_malformed();
    drain_results();
    test_random(1200);
    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d dates, checked %0d results: %0d ok, %0d malformed, %0d overflow.",
             n_sent, n_checked, n_ok, n_invalid, n_overflow);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
